### rtl/core/pfc_pkg.sv
// Package for the pixel format converter: format codes, register indexes and helpers.
`timescale 1ns / 1ps

package pfc_pkg;

   localparam int FmtWidth   = 3;
   localparam int PixWidth   = 32;
   localparam int BytesWidth = 3;
   localparam int CsrIdxWidth = 1;
   localparam int SumWidth   = 10;
   localparam int DivMulWidth = 11;
   localparam int DivShift   = 11;
   localparam logic [DivMulWidth-1:0] DivThreeMul = 11'd683;

   typedef enum logic [FmtWidth-1:0] {
      FMT_RGBA   = 3'd0,
      FMT_ARGB   = 3'd1,
      FMT_RGB    = 3'd2,
      FMT_RGB555 = 3'd3,
      FMT_RGB565 = 3'd4,
      FMT_LUM    = 3'd5,
      FMT_ALPHA  = 3'd6
   } fmt_type;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_SOURCE_FORMAT = 1'd0,
      CSR_DEST_FORMAT   = 1'd1
   } csr_idx_type;

   localparam logic [FmtWidth-1:0] SourceFormatReset = 3'd2;
   localparam logic [FmtWidth-1:0] DestFormatReset   = 3'd0;

   function automatic logic [BytesWidth-1:0] fmt_size(input logic [FmtWidth-1:0] f);
      logic [BytesWidth-1:0] n;
      case (fmt_type'(f))
         FMT_RGBA, FMT_ARGB:     n = 3'd4;
         FMT_RGB:                n = 3'd3;
         FMT_RGB555, FMT_RGB565: n = 3'd2;
         FMT_LUM, FMT_ALPHA:     n = 3'd1;
         default:                n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic logic [PixWidth-1:0] byte_mask(input logic [BytesWidth-1:0] n);
      logic [PixWidth-1:0] m;
      case (n)
         3'd0:    m = 32'h0000_0000;
         3'd1:    m = 32'h0000_00ff;
         3'd2:    m = 32'h0000_ffff;
         3'd3:    m = 32'h00ff_ffff;
         default: m = 32'hffff_ffff;
      endcase
      return m;
   endfunction

endpackage

### rtl/core/pixel_format_converter_top.sv
// Pixel format converter: three-stage pipeline from source format to destination format.
`timescale 1ns / 1ps
//
// Usage:
//   req_* carries one source pixel per transaction (req_valid, req_stall,
//   req_pixel_in). rsp_* returns one converted pixel per transaction
//   (rsp_valid, rsp_stall, rsp_pixel_out, rsp_out_bytes).
//   csr_* writes source_format (index 0) and dest_format (index 1); write
//   only while the pipeline is empty.
// Path: an accepted pixel moves through s1_ff, s2_ff and out_ff in that order,
//   and rsp_valid rises once it sits in out_ff.
// Throughput: 1 pixel per cycle while rsp_stall is low; the multiply-by-reciprocal
//   divide for luminance and the unpack/pack muxes each take one stage.
// Reset: synchronous, active high; empties the pipeline and loads
//   source_format = RGB, dest_format = RGBA.
// Stall: each stage holds when it is full and the one after it holds, so
//   bubbles are squeezed out; req_stall rises only when all three stages
//   are full and rsp_stall is high. A stalled response holds its payload.
//
module pixel_format_converter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pixel_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_out,
   output logic [2:0]  rsp_out_bytes,
   input  logic        csr_wr_en,
   input  logic [pfc_pkg::CsrIdxWidth-1:0] csr_addr,
   input  logic [2:0]  csr_wdata
);

   typedef struct packed {
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  a;
      logic        pass;
      logic [31:0] pass_pix;
   } s1_type;

   typedef struct packed {
      logic [31:0]                  packed_pix;
      logic [pfc_pkg::SumWidth-1:0] sum;
      logic                         is_lum;
   } s2_type;

   logic [2:0] src_ff, src_in;
   logic [2:0] dst_ff, dst_in;

   logic   v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic   en1, en2, en3;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   logic [31:0] out_ff, out_in;
   logic [2:0]  bytes_ff, bytes_in;

   logic [pfc_pkg::SumWidth+pfc_pkg::DivMulWidth-1:0] prod;
   logic [2:0]  dst_n;
   logic [31:0] dst_mask;

   assign dst_n    = pfc_pkg::fmt_size(dst_ff);
   assign dst_mask = pfc_pkg::byte_mask(dst_n);

   assign en3 = !v3_ff || !rsp_stall;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign req_stall = !en1;

   always_comb begin
      src_in = src_ff;
      dst_in = dst_ff;
      if (csr_wr_en) begin
         case (pfc_pkg::csr_idx_type'(csr_addr))
            pfc_pkg::CSR_SOURCE_FORMAT: src_in = csr_wdata;
            pfc_pkg::CSR_DEST_FORMAT:   dst_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: unpack to channels
   always_comb begin
      logic [15:0] w;
      w = req_pixel_in[15:0];
      s1_in = '0;
      s1_in.pass     = (src_ff == dst_ff);
      s1_in.pass_pix = req_pixel_in & dst_mask;
      case (pfc_pkg::fmt_type'(src_ff))
         pfc_pkg::FMT_RGBA: begin
            s1_in.r = req_pixel_in[7:0];
            s1_in.g = req_pixel_in[15:8];
            s1_in.b = req_pixel_in[23:16];
            s1_in.a = req_pixel_in[31:24];
         end
         pfc_pkg::FMT_ARGB: begin
            s1_in.g = req_pixel_in[7:0];
            s1_in.b = req_pixel_in[15:8];
            s1_in.a = req_pixel_in[23:16];
            s1_in.r = req_pixel_in[31:24];
         end
         pfc_pkg::FMT_RGB: begin
            s1_in.r = req_pixel_in[7:0];
            s1_in.g = req_pixel_in[15:8];
            s1_in.b = req_pixel_in[23:16];
            s1_in.a = 8'hff;
         end
         pfc_pkg::FMT_RGB555: begin
            s1_in.r = {w[14:10], 3'b000};
            s1_in.g = {w[9:5], 3'b000};
            s1_in.b = {w[4:0], 3'b000};
            s1_in.a = 8'hff;
         end
         pfc_pkg::FMT_RGB565: begin
            s1_in.r = {w[15:11], 3'b000};
            s1_in.g = {w[10:5], 2'b00};
            s1_in.b = {w[4:0], 3'b000};
            s1_in.a = 8'hff;
         end
         pfc_pkg::FMT_LUM: begin
            s1_in.r = req_pixel_in[7:0];
            s1_in.g = req_pixel_in[7:0];
            s1_in.b = req_pixel_in[7:0];
            s1_in.a = 8'hff;
         end
         pfc_pkg::FMT_ALPHA: begin
            s1_in.a = req_pixel_in[7:0];
         end
         default: ;
      endcase
   end

   // stage 2: pack, channel sum for luminance
   always_comb begin
      logic [31:0] pk;
      pk = '0;
      case (pfc_pkg::fmt_type'(dst_ff))
         pfc_pkg::FMT_RGBA:   pk = {s1_ff.a, s1_ff.b, s1_ff.g, s1_ff.r};
         pfc_pkg::FMT_ARGB:   pk = {s1_ff.r, s1_ff.a, s1_ff.b, s1_ff.g};
         pfc_pkg::FMT_RGB:    pk = {8'h00, s1_ff.b, s1_ff.g, s1_ff.r};
         pfc_pkg::FMT_RGB555: pk = {17'd0, s1_ff.r[7:3], s1_ff.g[7:3], s1_ff.b[7:3]};
         pfc_pkg::FMT_RGB565: pk = {16'd0, s1_ff.r[7:3], s1_ff.g[7:2], s1_ff.b[7:3]};
         pfc_pkg::FMT_ALPHA:  pk = {24'd0, s1_ff.a};
         default:             pk = '0;
      endcase
      s2_in.packed_pix = s1_ff.pass ? s1_ff.pass_pix : pk;
      s2_in.sum    = {2'b00, s1_ff.r} + {2'b00, s1_ff.g} + {2'b00, s1_ff.b};
      s2_in.is_lum = !s1_ff.pass && (dst_ff == pfc_pkg::FMT_LUM);
   end

   // stage 3: divide by three through reciprocal, final select
   assign prod = {{pfc_pkg::DivMulWidth{1'b0}}, s2_ff.sum} *
                 {{pfc_pkg::SumWidth{1'b0}}, pfc_pkg::DivThreeMul};

   always_comb begin
      out_in   = s2_ff.is_lum ? {24'd0, prod[pfc_pkg::DivShift +: 8]} : s2_ff.packed_pix;
      bytes_in = dst_n;
   end

   always_comb begin
      v1_in = en1 ? req_valid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_ff <= pfc_pkg::SourceFormatReset;
         dst_ff <= pfc_pkg::DestFormatReset;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
      end else begin
         src_ff <= src_in;
         dst_ff <= dst_in;
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) begin
         out_ff   <= out_in;
         bytes_ff <= bytes_in;
      end
   end

   assign rsp_valid     = v3_ff;
   assign rsp_pixel_out = out_ff;
   assign rsp_out_bytes = bytes_ff;

endmodule

### rtl/core/pfc_checker.sv
// Port-level checker for the pixel format converter, bound to the top level.
`timescale 1ns / 1ps

module pfc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_out,
   input logic [2:0]  rsp_out_bytes
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_out_bytes))
      else $error("stalled response changed");

   a_bytes_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_out_bytes <= 3'd4)
      else $error("out_bytes out of range");

   a_upper_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_bytes <= 3'd2 |->
         rsp_pixel_out[31:16] == 16'd0 &&
         (rsp_out_bytes == 3'd2 || rsp_pixel_out[15:8] == 8'd0))
      else $error("unused upper bytes not zero");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled while output free");

endmodule

bind pixel_format_converter_top pfc_checker u_pfc_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_pixel_out(rsp_pixel_out),
   .rsp_out_bytes(rsp_out_bytes)
);

### bench/pfc_checker.sv
// Checker for the pixel format converter: predicts each converted pixel and compares responses.
`timescale 1ns / 1ps

module pfc_scoreboard (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [31:0]                     req_pixel_in,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [31:0]                     rsp_pixel_out,
   input  logic [2:0]                      rsp_out_bytes,
   input  logic                            csr_wr_en,
   input  logic [pfc_pkg::CsrIdxWidth-1:0] csr_addr,
   input  logic [2:0]                      csr_wdata,
   output int                              mismatch_count,
   output int                              pending_count
);

   typedef struct packed {
      logic [31:0] pixel;
      logic [2:0]  nbytes;
   } converted_pixel_type;

   converted_pixel_type expected_pixels[$];
   logic [2:0] src_fmt;
   logic [2:0] dst_fmt;

   function automatic logic [2:0] bytes_per_pixel(input logic [2:0] f);
      logic [2:0] n;
      case (pfc_pkg::fmt_type'(f))
         pfc_pkg::FMT_RGBA, pfc_pkg::FMT_ARGB:     n = 3'd4;
         pfc_pkg::FMT_RGB:                         n = 3'd3;
         pfc_pkg::FMT_RGB555, pfc_pkg::FMT_RGB565: n = 3'd2;
         pfc_pkg::FMT_LUM, pfc_pkg::FMT_ALPHA:     n = 3'd1;
         default:                                  n = 3'd0;
      endcase
      return n;
   endfunction

   function automatic converted_pixel_type convert_pixel(input logic [2:0] src,
                                                         input logic [2:0] dst,
                                                         input logic [31:0] pix);
      logic [7:0]          r, g, b, a;
      logic [15:0]         w;
      int                  sum;
      logic [31:0]         word_out;
      logic [31:0]         keep;
      converted_pixel_type c;
      c.nbytes = bytes_per_pixel(dst);
      keep = (c.nbytes >= 3'd4) ? 32'hffff_ffff : ((32'd1 << (8 * c.nbytes)) - 32'd1);
      if (src == dst) begin
         c.pixel = pix & keep;
         return c;
      end
      r = 8'h00;
      g = 8'h00;
      b = 8'h00;
      a = 8'h00;
      w = pix[15:0];
      case (pfc_pkg::fmt_type'(src))
         pfc_pkg::FMT_RGBA:   {a, b, g, r} = pix;
         pfc_pkg::FMT_ARGB:   {r, a, b, g} = pix;
         pfc_pkg::FMT_RGB: begin
            {b, g, r} = pix[23:0];
            a = 8'hff;
         end
         pfc_pkg::FMT_RGB555: begin
            r = {w[14:10], 3'b000};
            g = {w[9:5], 3'b000};
            b = {w[4:0], 3'b000};
            a = 8'hff;
         end
         pfc_pkg::FMT_RGB565: begin
            r = {w[15:11], 3'b000};
            g = {w[10:5], 2'b00};
            b = {w[4:0], 3'b000};
            a = 8'hff;
         end
         pfc_pkg::FMT_LUM: begin
            r = pix[7:0];
            g = pix[7:0];
            b = pix[7:0];
            a = 8'hff;
         end
         pfc_pkg::FMT_ALPHA:  a = pix[7:0];
         default: ;
      endcase
      case (pfc_pkg::fmt_type'(dst))
         pfc_pkg::FMT_RGBA:   word_out = {a, b, g, r};
         pfc_pkg::FMT_ARGB:   word_out = {r, a, b, g};
         pfc_pkg::FMT_RGB:    word_out = {8'h00, b, g, r};
         pfc_pkg::FMT_RGB555: word_out = {17'h0, r[7:3], g[7:3], b[7:3]};
         pfc_pkg::FMT_RGB565: word_out = {16'h0, r[7:3], g[7:2], b[7:3]};
         pfc_pkg::FMT_LUM: begin
            sum = int'(r) + int'(g) + int'(b);
            word_out = 32'(sum / 3);
         end
         pfc_pkg::FMT_ALPHA:  word_out = {24'h0, a};
         default:             word_out = 32'h0;
      endcase
      c.pixel = word_out & keep;
      return c;
   endfunction

   always @(posedge clock) begin
      converted_pixel_type expected;
      if (reset) begin
         expected_pixels.delete();
         src_fmt <= pfc_pkg::SourceFormatReset;
         dst_fmt <= pfc_pkg::DestFormatReset;
         pending_count = 0;
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (pfc_pkg::csr_idx_type'(csr_addr))
               pfc_pkg::CSR_SOURCE_FORMAT: src_fmt <= csr_wdata;
               pfc_pkg::CSR_DEST_FORMAT:   dst_fmt <= csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected transaction: pixel_out %h, out_bytes %0d",
                      rsp_pixel_out, rsp_out_bytes);
               mismatch_count++;
            end else begin
               expected = expected_pixels.pop_front();
               if (rsp_pixel_out !== expected.pixel) begin
                  $error("pixel_out: expected %h, actual %h", expected.pixel, rsp_pixel_out);
                  mismatch_count++;
               end
               if (rsp_out_bytes !== expected.nbytes) begin
                  $error("out_bytes: expected %0d, actual %0d", expected.nbytes, rsp_out_bytes);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_pixels.push_back(convert_pixel(src_fmt, dst_fmt, req_pixel_in));
         pending_count = expected_pixels.size();
      end
   end

endmodule

### bench/tb_top.sv
// Testbench top for the pixel format converter: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [31:0]                     req_pixel_in;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [31:0]                     rsp_pixel_out;
   logic [2:0]                      rsp_out_bytes;
   logic                            csr_wr_en;
   logic [pfc_pkg::CsrIdxWidth-1:0] csr_addr;
   logic [2:0]                      csr_wdata;
   int                              mismatch_count;
   int                              pending_count;
   bit                              quiet;

   pixel_format_converter_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_out_bytes (rsp_out_bytes),
      .csr_wr_en     (csr_wr_en),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata)
   );

   pfc_scoreboard u_scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_out_bytes  (rsp_out_bytes),
      .csr_wr_en      (csr_wr_en),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall = !quiet && ($urandom_range(99) < 30);
      end
   end

   // Drive one pixel at a falling edge and hold it until the transaction completes.
   task automatic send_pixel(input logic [31:0] pix);
      if (!quiet && $urandom_range(99) < 30) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pixel_in = pix;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_formats(input logic [2:0] src, input logic [2:0] dst);
      csr_wr_en = 1'b1;
      csr_addr = pfc_pkg::CSR_SOURCE_FORMAT;
      csr_wdata = src;
      @(negedge clock);
      csr_addr = pfc_pkg::CSR_DEST_FORMAT;
      csr_wdata = dst;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   function automatic logic [31:0] pick_pixel();
      logic [31:0] p;
      case ($urandom_range(9))
         7:       p = 32'h0000_0000;
         8:       p = 32'hffff_ffff;
         9:       p = {8'($urandom_range(255)), 24'hff_ffff};
         default: p = $urandom;
      endcase
      return p;
   endfunction

   initial begin
      logic [31:0] directed_pixels[$];
      logic [5:0]  combo;
      quiet = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_pixel_in = 32'h0;
      csr_wr_en = 1'b0;
      csr_addr = pfc_pkg::CSR_SOURCE_FORMAT;
      csr_wdata = 3'd0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset formats first: RGB to RGBA
      directed_pixels = '{32'h0000_0000, 32'hffff_ffff, 32'h1234_5678, 32'h0000_ffff,
                          32'hffff_0000, 32'h0000_7c00, 32'h0000_03e0, 32'h0000_f800,
                          32'h0000_07e0, 32'h0000_001f, 32'h0000_00ff, 32'haaaa_aaaa,
                          32'h5555_5555};
      foreach (directed_pixels[i])
         send_pixel(directed_pixels[i]);
      drain_pipeline();

      // every source and destination pair, unknown code 7 included
      for (int c = 0; c < 64; c++) begin
         combo = 6'(c);
         quiet = (c >= 24 && c < 32);
         write_formats(combo[5:3], combo[2:0]);
         send_pixel(32'h0000_0000);
         send_pixel(32'hffff_ffff);
         repeat (28) send_pixel(pick_pixel());
         drain_pipeline();
      end

      quiet = 1'b0;
      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && pending_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

### filelist.f
rtl/core/pfc_pkg.sv
rtl/core/pixel_format_converter_top.sv
rtl/core/pfc_checker.sv
bench/pfc_checker.sv
bench/tb_top.sv
